// ===== rtl/bpam_pkg.sv =====
// Package for the bitboard piece attack mask core: board constants, piece codes,
// stage word types and the mask helper functions.
// No dependencies; used by every file under rtl/.
package bpam_pkg;

    localparam logic [63:0] FILE_A_BITS = 64'h0101_0101_0101_0101;
    localparam logic [63:0] FILE_H_BITS = 64'h8080_8080_8080_8080;
    localparam logic [63:0] NOT_GH_BITS = 64'h3f3f_3f3f_3f3f_3f3f;
    localparam logic [63:0] NOT_AB_BITS = 64'hfcfc_fcfc_fcfc_fcfc;

    localparam int NUM_LINES = 3;  // file, diagonal, anti-diagonal

    localparam logic [2:0] PIECE_BISHOP = 3'd2;
    localparam logic [2:0] PIECE_ROOK   = 3'd3;
    localparam logic [2:0] PIECE_QUEEN  = 3'd4;

    typedef logic [NUM_LINES-1:0][63:0] t_line_set;

    // Word held between the decode stage and the subtract stage.
    typedef struct packed {
        logic        use_diag;
        logic        use_orth;
        logic [63:0] leap;
        logic [63:0] occ;
        logic [63:0] bit_b;
        t_line_set   line;
        t_line_set   fwd;
    } t_stage1;

    // Word held between the subtract stage and the combine stage.
    typedef struct packed {
        logic        use_diag;
        logic        use_orth;
        logic [63:0] leap;
        logic [63:0] rank_att;
        t_line_set   line;
        t_line_set   fwd_sub;
        t_line_set   rev_sub;
    } t_stage2;

    function automatic logic [63:0] swap_bytes(input logic [63:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24],
                v[39:32], v[47:40], v[55:48], v[63:56]};
    endfunction

    // Diagonal (anti clear) or anti-diagonal (anti set) through sq, sq excluded.
    function automatic logic [63:0] diag_mask(input logic [5:0] sq, input logic anti);
        logic [63:0] m;
        logic [5:0]  s_idx;
        logic        on;
        m = '0;
        for (int s = 0; s < 64; s++) begin
            s_idx = 6'(s);
            if (anti) begin
                on = ({1'b0, s_idx[5:3]} + {1'b0, s_idx[2:0]})
                  == ({1'b0, sq[5:3]} + {1'b0, sq[2:0]});
            end else begin
                on = ({1'b0, s_idx[5:3]} + {1'b0, sq[2:0]})
                  == ({1'b0, sq[5:3]} + {1'b0, s_idx[2:0]});
            end
            m[s] = on && (s_idx != sq);
        end
        return m;
    endfunction

    function automatic logic [63:0] knight_mask(input logic [63:0] b);
        return (((b << 6)  | (b >> 10)) & NOT_GH_BITS)
             | (((b << 10) | (b >> 6))  & NOT_AB_BITS)
             | (((b << 17) | (b >> 15)) & ~FILE_A_BITS)
             | (((b << 15) | (b >> 17)) & ~FILE_H_BITS);
    endfunction

    function automatic logic [63:0] king_mask(input logic [63:0] b);
        return (b << 8) | (b >> 8)
             | (((b >> 1) | (b >> 9) | (b << 7)) & ~FILE_H_BITS)
             | (((b << 1) | (b << 9) | (b >> 7)) & ~FILE_A_BITS);
    endfunction

endpackage

// ===== rtl/bitboard_piece_attack_mask.sv =====
// Top level of the bitboard piece attack mask core: three-stage pipeline with
// stream handshakes. Depends on bpam_pkg and bpam_rank_fill.
//
// Stage registers: r_s1 (decode), r_s2 (subtract) and r_out (combine), with valid
// bits r_v1 to r_v3. Throughput: one word per cycle unless the output stalls; each
// stage holds one word and moves on when the stage after it is empty or moving, so
// a stalled output fills the bubbles.
// Reset (i_rst_n low, synchronous) clears the three stage valid bits.
module bitboard_piece_attack_mask_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // [5:0] square, [69:6] occupied, [71:70] zero
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] piece_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata    // [63:0] attacks
);

    logic              r_v1, r_v2, r_v3;
    bpam_pkg::t_stage1 r_s1, n_s1;
    bpam_pkg::t_stage2 r_s2, n_s2;
    logic [63:0]       r_out, n_out;

    logic        adv3, rdy2, rdy1;
    logic [5:0]  sq;
    logic [63:0] occ_in;
    logic [2:0]  pt;
    logic [63:0] rank_att;

    assign adv3 = !r_v3 || i_m_axis_tready;
    assign rdy2 = !r_v2 || adv3;
    assign rdy1 = !r_v1 || rdy2;

    assign o_s_axis_tready = rdy1;
    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tdata  = r_out;

    assign sq     = i_s_axis_tdata[5:0];
    assign occ_in = i_s_axis_tdata[69:6];
    assign pt     = i_s_axis_tuser;

    // Decode stage: square bit, line masks, masked occupancy and leaper sets.
    always_comb begin
        n_s1.bit_b    = 64'(1) << sq;
        n_s1.occ      = occ_in;
        n_s1.use_diag = (pt == bpam_pkg::PIECE_BISHOP) || (pt == bpam_pkg::PIECE_QUEEN);
        n_s1.use_orth = (pt == bpam_pkg::PIECE_ROOK) || (pt == bpam_pkg::PIECE_QUEEN);
        if (pt < bpam_pkg::PIECE_BISHOP) begin
            n_s1.leap = bpam_pkg::knight_mask(n_s1.bit_b);
        end else if (pt > bpam_pkg::PIECE_QUEEN) begin
            n_s1.leap = bpam_pkg::king_mask(n_s1.bit_b);
        end else begin
            n_s1.leap = '0;
        end
        n_s1.line[0] = n_s1.bit_b ^ (bpam_pkg::FILE_A_BITS << sq[2:0]);
        n_s1.line[1] = bpam_pkg::diag_mask(sq, 1'b0);
        n_s1.line[2] = bpam_pkg::diag_mask(sq, 1'b1);
        for (int i = 0; i < bpam_pkg::NUM_LINES; i++) begin
            n_s1.fwd[i] = occ_in & n_s1.line[i];
        end
    end

    // Subtract stage: rank fill, and forward and byte-reversed subtraction on each line.
    bpam_rank_fill u_rank_fill (
        .i_bit      (r_s1.bit_b),
        .i_occ      (r_s1.occ),
        .o_rank_att (rank_att)
    );

    always_comb begin
        n_s2.use_diag = r_s1.use_diag;
        n_s2.use_orth = r_s1.use_orth;
        n_s2.leap     = r_s1.leap;
        n_s2.rank_att = rank_att;
        n_s2.line     = r_s1.line;
        for (int i = 0; i < bpam_pkg::NUM_LINES; i++) begin
            n_s2.fwd_sub[i] = r_s1.fwd[i] - r_s1.bit_b;
            n_s2.rev_sub[i] = bpam_pkg::swap_bytes(r_s1.fwd[i])
                            - bpam_pkg::swap_bytes(r_s1.bit_b);
        end
    end

    // Combine stage: line hits merged by piece kind.
    always_comb begin
        logic [63:0] hits [bpam_pkg::NUM_LINES];
        for (int i = 0; i < bpam_pkg::NUM_LINES; i++) begin
            hits[i] = r_s2.line[i]
                    & (r_s2.fwd_sub[i] ^ bpam_pkg::swap_bytes(r_s2.rev_sub[i]));
        end
        n_out = r_s2.leap;
        if (r_s2.use_diag) begin
            n_out = n_out | hits[1] | hits[2];
        end
        if (r_s2.use_orth) begin
            n_out = n_out | hits[0] | r_s2.rank_att;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_s_axis_tvalid) begin
            r_s1 <= n_s1;
        end
        if (rdy2 && r_v1) begin
            r_s2 <= n_s2;
        end
        if (adv3 && r_v2) begin
            r_out <= n_out;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_v1 && !r_v2 && !r_v3)
        else $error("stage valid bits not cleared by reset");

    a_leap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> $countones(r_s1.leap) <= 8)
        else $error("leaper set has more than eight squares");

    a_leap_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && (r_s2.leap != '0) |-> !r_s2.use_diag && !r_s2.use_orth)
        else $error("leaper word also marked as slider");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !rdy2 |=> r_v2 && $stable(r_s2))
        else $error("blocked middle stage lost or changed its word");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !rdy2 |=> r_v1 && $stable(r_s1))
        else $error("blocked first stage lost or changed its word");

endmodule

// ===== rtl/bpam_rank_fill.sv =====
// Rank attacks of a slider: blocked seven-step ray fill east and west.
// Depends on bpam_pkg for the edge-file masks.
module bpam_rank_fill (
    input  logic [63:0] i_bit,
    input  logic [63:0] i_occ,
    output logic [63:0] o_rank_att
);

    logic [63:0] east;
    logic [63:0] west;

    always_comb begin
        east = (i_bit << 1) & ~bpam_pkg::FILE_A_BITS;
        west = (i_bit >> 1) & ~bpam_pkg::FILE_H_BITS;
        // Each step extends only past squares that are empty.
        for (int k = 0; k < 6; k++) begin
            east = east | (((east & ~i_occ) << 1) & ~bpam_pkg::FILE_A_BITS);
            west = west | (((west & ~i_occ) >> 1) & ~bpam_pkg::FILE_H_BITS);
        end
        o_rank_att = east | west;
    end

endmodule

// ===== bench/tb_bitboard_piece_attack_mask_core.sv =====
// Testbench for bitboard_piece_attack_mask_core: directed and random attack queries
// with random gaps and output stalls, each result checked against a local attack model.
// Depends on bpam_pkg and the core RTL; self-contained otherwise.
module tb_bitboard_piece_attack_mask_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]  PT_KNIGHT    = 3'd1;
    localparam logic [2:0]  PT_KING      = 3'd5;
    localparam logic [2:0]  PT_ALIAS_LOW = 3'd0;
    localparam logic [2:0]  PT_ALIAS_SIX = 3'd6;
    localparam logic [2:0]  PT_ALIAS_TOP = 3'd7;
    localparam logic [63:0] COL_A        = 64'h0101_0101_0101_0101;
    localparam logic [63:0] COL_H        = 64'h8080_8080_8080_8080;
    localparam logic [63:0] COLS_A_TO_F  = 64'h3f3f_3f3f_3f3f_3f3f;
    localparam logic [63:0] COLS_C_TO_H  = 64'hfcfc_fcfc_fcfc_fcfc;
    localparam logic [63:0] FULL_BOARD   = '1;
    localparam int          CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [63:0] attacks;
        logic [5:0]  sq;
        logic [2:0]  pt;
    } t_attack_query;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [71:0] i_s_axis_tdata;   // [5:0] square, [69:6] occupied, [71:70] zero
    logic [2:0]  i_s_axis_tuser;   // [2:0] piece_type
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [63:0] o_m_axis_tdata;   // [63:0] attacks

    t_attack_query pending_attacks[$];
    int            mismatch_count;
    int            cycle_count;
    bit            bursting;

    bitboard_piece_attack_mask_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- attack model ----------------

    function automatic logic [63:0] rank_flip(input logic [63:0] v);
        logic [63:0] r;
        for (int k = 0; k < 8; k++) begin
            r[8*k +: 8] = v[8*(7-k) +: 8];
        end
        return r;
    endfunction

    function automatic logic [63:0] slide_east(input logic [63:0] b, input logic [63:0] occ);
        logic [63:0] m;
        m = (b << 1) & ~COL_A;
        for (int k = 0; k < 6; k++) begin
            m |= ((m & ~occ) << 1) & ~COL_A;
        end
        return m;
    endfunction

    function automatic logic [63:0] slide_west(input logic [63:0] b, input logic [63:0] occ);
        logic [63:0] m;
        m = (b >> 1) & ~COL_H;
        for (int k = 0; k < 6; k++) begin
            m |= ((m & ~occ) >> 1) & ~COL_H;
        end
        return m;
    endfunction

    // Line mask of one diagonal through sq, sq itself left out.
    function automatic logic [63:0] diagonal_through(input int sq, input bit anti);
        logic [63:0] m;
        int          f0;
        int          r0;
        m  = '0;
        f0 = sq % 8;
        r0 = sq / 8;
        for (int s = 0; s < 64; s++) begin
            if (s != sq && (anti ? ((s / 8) + (s % 8) == r0 + f0)
                                 : ((s / 8) - (s % 8) == r0 - f0))) begin
                m[s] = 1'b1;
            end
        end
        return m;
    endfunction

    // Forward and byte-reversed subtraction; the xor keeps the squares up to
    // the first blocker in both directions.
    function automatic logic [63:0] line_reach(input logic [63:0] b, input logic [63:0] occ,
                                               input logic [63:0] line);
        logic [63:0] up;
        logic [63:0] down;
        up   = occ & line;
        down = rank_flip(up);
        up   = up - b;
        down = down - rank_flip(b);
        return line & (up ^ rank_flip(down));
    endfunction

    function automatic logic [63:0] attack_set(input logic [5:0] sq, input logic [63:0] occ,
                                               input logic [2:0] pt);
        logic [63:0] b;
        logic [63:0] a;
        b = 64'd1 << sq;
        a = '0;
        if (pt < bpam_pkg::PIECE_BISHOP) begin
            a = (((b << 6)  | (b >> 10)) & COLS_A_TO_F)
              | (((b << 10) | (b >> 6))  & COLS_C_TO_H)
              | (((b << 17) | (b >> 15)) & ~COL_A)
              | (((b << 15) | (b >> 17)) & ~COL_H);
        end else if (pt > bpam_pkg::PIECE_QUEEN) begin
            a = (b << 8) | (b >> 8)
              | (((b >> 1) | (b >> 9) | (b << 7)) & ~COL_H)
              | (((b << 1) | (b << 9) | (b >> 7)) & ~COL_A);
        end else begin
            if (pt != bpam_pkg::PIECE_ROOK) begin
                a |= line_reach(b, occ, diagonal_through(int'(sq), 1'b0))
                   | line_reach(b, occ, diagonal_through(int'(sq), 1'b1));
            end
            if (pt > bpam_pkg::PIECE_BISHOP) begin
                a |= line_reach(b, occ, b ^ (COL_A << sq[2:0]))
                   | slide_east(b, occ) | slide_west(b, occ);
            end
        end
        return a;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [63:0] random_board();
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        x = {$urandom, $urandom};
        y = {$urandom, $urandom};
        z = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            0:       return x;
            1, 2:    return x & y;
            3:       return x & y & z;
            4:       return x | y;
            5:       return $urandom_range(0, 1) ? FULL_BOARD : '0;
            default: return 64'd1 << $urandom_range(0, 63);
        endcase
    endfunction

    function automatic logic [2:0] random_piece();
        if ($urandom_range(0, 19) == 0) begin
            return 3'($urandom_range(0, 2) == 0 ? PT_ALIAS_LOW
                    : ($urandom_range(0, 1) ? PT_ALIAS_SIX : PT_ALIAS_TOP));
        end
        return 3'($urandom_range(PT_KNIGHT, PT_KING));
    endfunction

    // Offers one word and returns in the time step of the edge that took it.
    task automatic send_query(input logic [5:0] sq, input logic [63:0] occ,
                              input logic [2:0] pt);
        int            gap;
        t_attack_query q;
        gap = bursting ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, occ, sq};
        i_s_axis_tuser  <= pt;
        do @(posedge i_clk); while (!o_s_axis_tready);
        q.attacks = attack_set(sq, occ, pt);
        q.sq      = sq;
        q.pt      = pt;
        pending_attacks.push_back(q);
    endtask

    // Holds off the input until every outstanding result has come out.
    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_attacks.size() != 0);
    endtask

    // ---------------- tests ----------------

    task automatic test_leapers();
        send_query(6'd0,  '0,                 PT_KNIGHT);
        send_query(6'd63, FULL_BOARD,         PT_KNIGHT);
        send_query(6'd36, {$urandom, $urandom}, PT_KNIGHT);
        send_query(6'd0,  FULL_BOARD,         PT_KING);
        send_query(6'd63, '0,                 PT_KING);
        send_query(6'd7,  {$urandom, $urandom}, PT_KING);
        send_query(6'd56, 64'h00ff_0000_0000_ff00, PT_KING);
    endtask

    task automatic test_sliders();
        send_query(6'd0,  '0,                   bpam_pkg::PIECE_BISHOP);
        send_query(6'd63, FULL_BOARD,           bpam_pkg::PIECE_BISHOP);
        send_query(6'd27, 64'h0042_0000_0000_2400, bpam_pkg::PIECE_BISHOP);
        send_query(6'd0,  FULL_BOARD,           bpam_pkg::PIECE_ROOK);
        send_query(6'd63, '0,                   bpam_pkg::PIECE_ROOK);
        send_query(6'd35, 64'h0800_0000_8100_0008, bpam_pkg::PIECE_ROOK);
        send_query(6'd7,  '0,                   bpam_pkg::PIECE_QUEEN);
        send_query(6'd56, FULL_BOARD,           bpam_pkg::PIECE_QUEEN);
        send_query(6'd28, {$urandom, $urandom} & {$urandom, $urandom},
                   bpam_pkg::PIECE_QUEEN);
    endtask

    // Type codes outside one to five fold onto knight or king.
    task automatic test_folded_types();
        send_query(6'd18, FULL_BOARD,           PT_ALIAS_LOW);
        send_query(6'd45, '0,                   PT_ALIAS_SIX);
        send_query(6'd9,  {$urandom, $urandom}, PT_ALIAS_TOP);
    endtask

    task automatic test_random_queries(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) begin
                bursting = ($urandom_range(0, 3) == 0);
            end
            if (i == count / 2) begin
                wait_for_results();
            end
            send_query(6'($urandom_range(0, 63)), random_board(), random_piece());
        end
        bursting = 1'b0;
    endtask

    // ---------------- result side ----------------

    initial begin
        int stall;
        i_m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = bursting ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        t_attack_query q;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_attacks.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word, expected none actual %h", $time,
                         o_m_axis_tdata);
            end else begin
                q = pending_attacks.pop_front();
                if (o_m_axis_tdata !== q.attacks) begin
                    mismatch_count++;
                    $display("%0t: attacks sq=%0d pt=%0d expected %h actual %h", $time,
                             q.sq, q.pt, q.attacks, o_m_axis_tdata);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $time,
                     pending_attacks.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        mismatch_count   = 0;
        cycle_count      = 0;
        bursting         = 1'b0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_leapers();
        test_sliders();
        test_folded_types();
        wait_for_results();
        test_random_queries(850);
        wait_for_results();
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && pending_attacks.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bpam_pkg.sv
rtl/bpam_rank_fill.sv
rtl/bitboard_piece_attack_mask.sv
bench/tb_bitboard_piece_attack_mask_core.sv
